>>> src/can_tp_reassembler_core_macros.svh
// assertion macros shared by the reassembler checker
`ifndef CAN_TP_REASSEMBLER_CORE_MACROS_SVH
`define CAN_TP_REASSEMBLER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define CANTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CANTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cantp_pkg.sv
// shared types and constants of the can-tp reassembler
`default_nettype none

package cantp_pkg;

    localparam int LEN_W  = 12;
    localparam int DLC_W  = 4;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = 3;

    // pci type codes (upper nibble of byte 0)
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    localparam logic [DLC_W-1:0] FRAME_BYTES     = 4'd8;
    localparam logic [CNT_W-1:0] FIRST_CHUNK_MAX = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_FINISH
    } cantp_state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic write;
        logic finish;
    } cantp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic wr_done;
    } cantp_sts_t;

endpackage

`default_nettype wire

>>> src/can_tp_reassembler_core.sv
// top level of the can-tp receive reassembler
//
// input channel: in_valid / in_ready carries one item: func selects between a
// received can frame (frame_dlc, byte0..byte7) and a read of one buffer byte
// at read_index.
// output channel: out_valid / out_ready returns one result item per input
// item: complete, busy_res, msg_len and read_byte.
// timing: one item at a time. an item is accepted, then decoded.
// a read then goes straight to finish. a frame writes its stored payload
// bytes one at a time (0 to 7, through the byte-wide buffer write port),
// closes the write step, then goes to finish.
// the result shows the cycle after finish.
// the result sits in an output register, so a new item is taken while a
// result still waits; if the receiver stalls, the next item waits in the
// finish step until the output register frees up.
// reset clears the transfer state (no transfer active, count zero); the
// buffer contents are not cleared and no clearing pass runs.
`default_nettype none

module can_tp_reassembler_core #(
    parameter int MAX_MESSAGE = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic [cantp_pkg::DLC_W-1:0]   frame_dlc,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte0,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte1,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte2,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte3,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte4,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte5,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte6,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte7,
    input  wire logic [cantp_pkg::IDX_W-1:0]   read_index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               complete,
    output logic                               busy_res,
    output logic [cantp_pkg::LEN_W-1:0]        msg_len,
    output logic [cantp_pkg::BYTE_W-1:0]       read_byte
);
    import cantp_pkg::*;

    // command / status between controller and datapath
    cantp_cmd_t cmd;
    cantp_sts_t sts;

    // sequencer: accept, decode, byte writes, finish
    cantp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // frame decode, message buffer, transfer state and result register
    cantp_datapath #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (func),
        .frame_dlc  (frame_dlc),
        .byte0      (byte0),
        .byte1      (byte1),
        .byte2      (byte2),
        .byte3      (byte3),
        .byte4      (byte4),
        .byte5      (byte5),
        .byte6      (byte6),
        .byte7      (byte7),
        .read_index (read_index),
        .complete   (complete),
        .busy_res   (busy_res),
        .msg_len    (msg_len),
        .read_byte  (read_byte)
    );

endmodule

`default_nettype wire

>>> src/cantp_ctrl.sv
// controller state machine of the can-tp reassembler
`default_nettype none

module cantp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire cantp_pkg::cantp_sts_t sts,
    output cantp_pkg::cantp_cmd_t cmd
);
    import cantp_pkg::*;

    cantp_state_t state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = sts.is_read ? ST_FINISH : ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.wr_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE: cmd.decode = 1'b1;
            ST_WRITE:  cmd.write  = !sts.wr_done;
            ST_FINISH: cmd.finish = out_free;
            default:   cmd        = '0;
        endcase
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

`default_nettype wire

>>> src/cantp_datapath.sv
// datapath of the can-tp reassembler: frame decode, byte buffer, state, result register
`default_nettype none

module cantp_datapath #(
    parameter int MAX_MESSAGE = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cantp_pkg::cantp_cmd_t         cmd,
    output cantp_pkg::cantp_sts_t              sts,
    input  wire logic                          func,
    input  wire logic [cantp_pkg::DLC_W-1:0]   frame_dlc,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte0,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte1,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte2,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte3,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte4,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte5,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte6,
    input  wire logic [cantp_pkg::BYTE_W-1:0]  byte7,
    input  wire logic [cantp_pkg::IDX_W-1:0]   read_index,
    output logic                               complete,
    output logic                               busy_res,
    output logic [cantp_pkg::LEN_W-1:0]        msg_len,
    output logic [cantp_pkg::BYTE_W-1:0]       read_byte
);
    import cantp_pkg::*;

    localparam int AW = $clog2(MAX_MESSAGE);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_MESSAGE);
    localparam logic [LEN_W:0]   MAX_WIDE = (LEN_W+1)'(MAX_MESSAGE);

    logic [BYTE_W-1:0] mem [MAX_MESSAGE];

    // captured item
    logic              func_reg;
    logic [DLC_W-1:0]  dlc_reg;
    logic [BYTE_W-1:0] d_reg [8];
    logic [IDX_W-1:0]  ridx_reg;

    // message state
    logic [LEN_W-1:0]  rcv_reg, tot_reg;
    logic [3:0]        seq_reg;
    logic              act_reg;

    // plan from decode, committed at finish
    logic [LEN_W-1:0]  p_rcv_reg, p_tot_reg, p_rcv_next, p_tot_next;
    logic [3:0]        p_seq_reg, p_seq_next;
    logic              p_act_reg, p_act_next, p_cpl_reg, p_cpl_next;
    logic              p_rdok_reg, p_rdok_next;
    logic [BYTE_W-1:0] rd_data_reg;

    // byte write sequencer
    logic [CNT_W-1:0]  wr_left_reg, wr_left_next;
    logic [CNT_W-1:0]  wr_src_reg, wr_src_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;

    // result register
    logic              cpl_out_reg, busy_out_reg;
    logic [LEN_W-1:0]  len_out_reg;
    logic [BYTE_W-1:0] rbyte_out_reg;

    logic [3:0]        frame_kind, pci_low;
    logic [DLC_W-1:0]  dlc_m1;
    logic [CNT_W-1:0]  chunk;
    logic [LEN_W:0]    sum;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  ridx_ext;

    assign sts.is_read = func_reg;
    assign sts.wr_done = (wr_left_reg == '0);

    assign frame_kind = d_reg[0][7:4];
    assign pci_low    = d_reg[0][3:0];
    assign dlc_m1     = dlc_reg - 4'd1;
    assign first_len  = {pci_low, d_reg[1]};
    assign ridx_ext   = LEN_W'(ridx_reg);

    // frame decode
    always_comb
    begin
        p_rcv_next   = rcv_reg;
        p_tot_next   = tot_reg;
        p_seq_next   = seq_reg;
        p_act_next   = act_reg;
        p_cpl_next   = 1'b0;
        p_rdok_next  = func_reg && (ridx_ext < rcv_reg) && (ridx_ext < MAX_LEN);
        wr_left_next = '0;
        wr_src_next  = 3'd1;
        wr_addr_next = '0;
        chunk        = 3'(dlc_m1);
        sum          = {1'b0, rcv_reg} + (LEN_W+1)'(chunk);
        if (!func_reg && dlc_reg != '0)
        begin
            unique case (frame_kind)
                PCI_SINGLE:
                begin
                    if (!(pci_low > dlc_m1 || LEN_W'(pci_low) > MAX_LEN))
                    begin
                        wr_left_next = 3'(pci_low);
                        p_rcv_next   = LEN_W'(pci_low);
                        p_tot_next   = LEN_W'(pci_low);
                        p_act_next   = 1'b0;
                        p_cpl_next   = 1'b1;
                    end
                end
                PCI_FIRST:
                begin
                    if (first_len <= MAX_LEN)
                    begin
                        if (dlc_reg == FRAME_BYTES)
                            chunk = FIRST_CHUNK_MAX;
                        else if (dlc_reg >= 4'd2)
                            chunk = 3'(dlc_reg - 4'd2);
                        else
                            chunk = '0;
                        wr_left_next = chunk;
                        wr_src_next  = 3'd2;
                        p_rcv_next   = LEN_W'(chunk);
                        p_tot_next   = first_len;
                        p_seq_next   = 4'd1;
                        p_act_next   = 1'b1;
                    end
                end
                PCI_CONSEC:
                begin
                    if (act_reg)
                    begin
                        if (pci_low != seq_reg || rcv_reg > MAX_LEN || sum > MAX_WIDE)
                        begin
                            // sequence error or overflow: abort
                            p_act_next = 1'b0;
                            p_rcv_next = '0;
                        end
                        else
                        begin
                            wr_left_next = chunk;
                            wr_addr_next = AW'(rcv_reg);
                            p_rcv_next   = sum[LEN_W-1:0];
                            p_seq_next   = (seq_reg == 4'hF) ? 4'd1 : seq_reg + 4'd1;
                            if (sum[LEN_W-1:0] >= tot_reg)
                            begin
                                p_act_next = 1'b0;
                                p_cpl_next = 1'b1;
                            end
                        end
                    end
                end
                default: p_cpl_next = 1'b0;
            endcase
        end
    end

    // capture, plan, buffer port and result register (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            dlc_reg  <= (frame_dlc > FRAME_BYTES) ? FRAME_BYTES : frame_dlc;
            d_reg[0] <= byte0;
            d_reg[1] <= byte1;
            d_reg[2] <= byte2;
            d_reg[3] <= byte3;
            d_reg[4] <= byte4;
            d_reg[5] <= byte5;
            d_reg[6] <= byte6;
            d_reg[7] <= byte7;
            ridx_reg <= read_index;
        end
        if (cmd.decode)
        begin
            p_rcv_reg   <= p_rcv_next;
            p_tot_reg   <= p_tot_next;
            p_seq_reg   <= p_seq_next;
            p_act_reg   <= p_act_next;
            p_cpl_reg   <= p_cpl_next;
            p_rdok_reg  <= p_rdok_next;
            wr_src_reg  <= wr_src_next;
            wr_addr_reg <= wr_addr_next;
            rd_data_reg <= mem[AW'(ridx_reg)];
        end
        else if (cmd.write)
        begin
            mem[wr_addr_reg] <= d_reg[wr_src_reg];
            wr_src_reg       <= wr_src_reg + 3'd1;
            wr_addr_reg      <= wr_addr_reg + AW'(1);
        end
        if (cmd.finish)
        begin
            cpl_out_reg   <= p_cpl_reg;
            busy_out_reg  <= p_act_reg;
            len_out_reg   <= p_rcv_reg;
            rbyte_out_reg <= p_rdok_reg ? rd_data_reg : '0;
        end
    end

    // message state and write counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_reg     <= '0;
            tot_reg     <= '0;
            seq_reg     <= '0;
            act_reg     <= 1'b0;
            wr_left_reg <= '0;
        end
        else
        begin
            if (cmd.decode)
                wr_left_reg <= wr_left_next;
            else if (cmd.write)
                wr_left_reg <= wr_left_reg - 3'd1;
            if (cmd.finish)
            begin
                rcv_reg <= p_rcv_reg;
                tot_reg <= p_tot_reg;
                seq_reg <= p_seq_reg;
                act_reg <= p_act_reg;
            end
        end
    end

    assign complete  = cpl_out_reg;
    assign busy_res  = busy_out_reg;
    assign msg_len   = len_out_reg;
    assign read_byte = rbyte_out_reg;

endmodule

`default_nettype wire

>>> src/cantp_checker.sv
// port-level checker of the can-tp reassembler and its bind
`default_nettype none
`include "can_tp_reassembler_core_macros.svh"

module cantp_checker #(
    parameter int MAX_MESSAGE = 128
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          complete,
    input wire logic                          busy_res,
    input wire logic [cantp_pkg::LEN_W-1:0]   msg_len,
    input wire logic [cantp_pkg::BYTE_W-1:0]  read_byte
);
    import cantp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE);

    // one item in flight: no accept right after an accept
    `CANTP_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "accept twice in a row")

    // a stalled result holds
    `CANTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({complete, busy_res, msg_len, read_byte}), "stalled result changed")

    // a completed message ends the transfer
    `CANTP_ASSERT_NOW(a_cpl_idle, clk, rst_n, out_valid && complete, !busy_res, "complete while busy")

    // count never passes the buffer size
    `CANTP_ASSERT_NOW(a_len_max, clk, rst_n, out_valid, msg_len <= MAX_LEN, "msg_len beyond buffer")

endmodule

bind can_tp_reassembler_core cantp_checker #(
    .MAX_MESSAGE (MAX_MESSAGE)
) u_cantp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .complete  (complete),
    .busy_res  (busy_res),
    .msg_len   (msg_len),
    .read_byte (read_byte)
);

`default_nettype wire

>>> tb/sv/tb_can_tp_reassembler_core.sv
// self-checking testbench for the can-tp receive reassembler core
`timescale 1ns / 100ps

module tb_can_tp_reassembler_core;
    import cantp_pkg::*;

    localparam int MSG_MAX        = 128;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_ITEMS   = 650;

    // item kinds on the func input
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // one input item as it sits on the ports
    typedef struct packed {
        logic                          func;
        logic [DLC_W-1:0]              dlc;
        logic [7:0][BYTE_W-1:0]        data;
        logic [IDX_W-1:0]              read_index;
    } frame_item_t;

    // one result item
    typedef struct packed {
        logic                  complete;
        logic                  busy;
        logic [LEN_W-1:0]      len;
        logic [BYTE_W-1:0]     rbyte;
    } reply_t;

    // clock, reset and ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                func = 1'b0;
    logic [DLC_W-1:0]    frame_dlc = '0;
    logic [BYTE_W-1:0]   byte0 = '0;
    logic [BYTE_W-1:0]   byte1 = '0;
    logic [BYTE_W-1:0]   byte2 = '0;
    logic [BYTE_W-1:0]   byte3 = '0;
    logic [BYTE_W-1:0]   byte4 = '0;
    logic [BYTE_W-1:0]   byte5 = '0;
    logic [BYTE_W-1:0]   byte6 = '0;
    logic [BYTE_W-1:0]   byte7 = '0;
    logic [IDX_W-1:0]    read_index = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                complete;
    logic                busy_res;
    logic [LEN_W-1:0]    msg_len;
    logic [BYTE_W-1:0]   read_byte;

    // items waiting to be sent, and results still owed by the block
    frame_item_t frame_q[$];
    reply_t      pending_replies[$];
    frame_item_t on_bus = '0;
    reply_t      next_reply;
    reply_t      got_reply;
    bit          holding;

    // predictor state: our own copy of the reassembly context
    logic [BYTE_W-1:0] rx_buf [MSG_MAX];
    int                rx_count;
    int                rx_total;
    logic [3:0]        rx_seq;
    bit                rx_active;

    // bookkeeping
    int items_sent;
    int total_items;
    int err_count;
    int frames_sent;
    int reads_sent;
    int messages_done;
    int longest_len;
    int idle_cycles;

    always #6 clk = ~clk;

    can_tp_reassembler_core #(
        .MAX_MESSAGE(MSG_MAX)
    ) DUT (.*);

    // ---------------------------------------------------------------
    // predictor: applies one accepted item to the reassembly context
    // ---------------------------------------------------------------
    task automatic reassemble_step(input frame_item_t it, output reply_t r);
        int dlc;
        int low;
        int len;
        int chunk;
        int base;
        int src;
        logic [3:0] ptype;
        bit done;
        done = 1'b0;
        r = '0;
        if (it.func == FUNC_READ)
        begin
            // only positions already filled in the current message answer
            if (it.read_index < rx_count && it.read_index < MSG_MAX)
                r.rbyte = rx_buf[it.read_index];
        end
        else
        begin
            // dlc codes above eight mean a full eight-byte frame
            dlc = (it.dlc > FRAME_BYTES) ? 8 : int'(it.dlc);
            ptype = it.data[0][7:4];
            low = it.data[0][3:0];
            chunk = 0;
            base = 0;
            src = 1;
            if (dlc != 0)
            begin
                if (ptype == PCI_SINGLE)
                begin
                    // whole message in one frame, length must fit the frame
                    if (low <= dlc - 1 && low <= MSG_MAX)
                    begin
                        chunk = low;
                        rx_count = low;
                        rx_total = low;
                        rx_active = 1'b0;
                        done = 1'b1;
                    end
                end
                else if (ptype == PCI_FIRST)
                begin
                    // 12-bit total length; one that fits the buffer replaces any transfer in flight
                    len = {low[3:0], it.data[1]};
                    if (len <= MSG_MAX)
                    begin
                        if (dlc >= 8)
                            chunk = FIRST_CHUNK_MAX;
                        else if (dlc >= 2)
                            chunk = dlc - 2;
                        src = 2;
                        rx_total = len;
                        rx_count = chunk;
                        rx_seq = 4'd1;
                        rx_active = 1'b1;
                    end
                end
                else if (ptype == PCI_CONSEC && rx_active)
                begin
                    if (low != rx_seq)
                    begin
                        // sequence slip kills the transfer
                        rx_active = 1'b0;
                        rx_count = 0;
                    end
                    else if (rx_count > MSG_MAX || dlc - 1 > MSG_MAX - rx_count)
                    begin
                        // chunk would run past the end of the buffer
                        rx_active = 1'b0;
                        rx_count = 0;
                    end
                    else
                    begin
                        chunk = dlc - 1;
                        base = rx_count;
                        rx_count = (rx_count + chunk) & 12'hFFF;
                        rx_seq = rx_seq + 4'd1;
                        if (rx_seq == 4'd0)
                            rx_seq = 4'd1;
                        if (rx_count >= rx_total)
                        begin
                            rx_active = 1'b0;
                            done = 1'b1;
                        end
                    end
                end
                // payload lands in the buffer
                for (int i = 0; i < chunk; i++)
                begin
                    if (base + i < MSG_MAX)
                        rx_buf[base + i] = it.data[src + i];
                end
            end
        end
        r.complete = done;
        r.busy = rx_active;
        r.len = rx_count[LEN_W-1:0];
    endtask

    // ---------------------------------------------------------------
    // item builders
    // ---------------------------------------------------------------
    function automatic frame_item_t make_frame(int dlc, logic [7:0] pci);
        frame_item_t f;
        f.func = FUNC_FRAME;
        f.dlc = 4'(dlc);
        for (int i = 0; i < 8; i++)
            f.data[i] = 8'($urandom);
        f.data[0] = pci;
        f.read_index = 7'($urandom);
        return f;
    endfunction

    function automatic frame_item_t single_frame(int dlc, int low);
        return make_frame(dlc, {PCI_SINGLE, 4'(low)});
    endfunction

    function automatic frame_item_t first_frame(int dlc, int len);
        frame_item_t f;
        f = make_frame(dlc, {PCI_FIRST, 4'(len >> 8)});
        f.data[1] = 8'(len);
        return f;
    endfunction

    function automatic frame_item_t cons_frame(int dlc, int seq);
        return make_frame(dlc, {PCI_CONSEC, 4'(seq)});
    endfunction

    function automatic frame_item_t read_item(int idx);
        frame_item_t f;
        f = make_frame($urandom_range(15, 0), 8'($urandom));
        f.func = FUNC_READ;
        f.read_index = 7'(idx);
        return f;
    endfunction

    // frames the block must drop: empty frame or unknown pci type
    function automatic frame_item_t noise_frame();
        if ($urandom_range(1) == 0)
            return make_frame(0, 8'($urandom));
        return make_frame($urandom_range(15, 1),
                          {4'($urandom_range(15, 3)), 4'($urandom)});
    endfunction

    // full frame, now and then with a dlc code above eight
    function automatic int full_dlc();
        return ($urandom_range(4) == 0) ? $urandom_range(15, 9) : 8;
    endfunction

    // reads and junk sprinkled between the frames of a transfer
    task automatic maybe_interleave();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            frame_q.push_back(read_item($urandom_range(MSG_MAX - 1, 0)));
        else if (r < 16)
            frame_q.push_back(noise_frame());
    endtask

    // one message: single frame, or first frame plus consecutive frames.
    // mangle breaks it (bad length, sequence slip or an abandoned transfer),
    // full sends only eight-byte frames so long messages overrun the buffer
    task automatic add_message(input int len, input bit mangle, input bit full);
        int dlc;
        int pos;
        int rem;
        int cf;
        int bad_cf;
        bit slip;
        logic [3:0] seq;
        if (len <= 7 && !full && $urandom_range(3) != 0)
        begin
            if (mangle)
                dlc = $urandom_range(len, 0);
            else
            begin
                dlc = $urandom_range(8, len + 1);
                if (dlc == 8 && $urandom_range(2) == 0)
                    dlc = $urandom_range(15, 9);
            end
            frame_q.push_back(single_frame(dlc, len));
        end
        else
        begin
            dlc = ($urandom_range(5) == 0 && !full) ? $urandom_range(7, 1) : full_dlc();
            frame_q.push_back(first_frame(dlc, len));
            if (dlc >= 8)
                pos = 6;
            else if (dlc >= 2)
                pos = dlc - 2;
            else
                pos = 0;
            seq = 4'd1;
            cf = 0;
            bad_cf = mangle ? $urandom_range(4, 0) : -1;
            slip = $urandom_range(1);
            do
            begin
                maybe_interleave();
                rem = len - pos;
                if (full)
                    dlc = full_dlc();
                else if (rem >= 7)
                    dlc = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : full_dlc();
                else if (rem > 0)
                    dlc = ($urandom_range(4) == 0) ? full_dlc() : rem + 1;
                else
                    dlc = $urandom_range(8, 1);
                if (cf == bad_cf)
                begin
                    // either a wrong sequence number or the sender just gives up
                    if (slip)
                        frame_q.push_back(cons_frame(dlc, seq + 4'($urandom_range(14, 1))));
                    return;
                end
                frame_q.push_back(cons_frame(dlc, seq));
                pos += ((dlc > 8) ? 8 : dlc) - 1;
                seq = (seq == 4'd15) ? 4'd1 : seq + 4'd1;
                cf++;
            end
            while (pos < len);
        end
    endtask

    // short burst of reads after a message, mostly inside its length
    task automatic add_reads(input int len);
        int n;
        n = $urandom_range(3, 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(4) == 0)
                frame_q.push_back(read_item($urandom_range(MSG_MAX - 1, 0)));
            else
                frame_q.push_back(read_item($urandom_range((len + 1 > 127) ? 127 : len + 1, 0)));
        end
    endtask

    // ---------------------------------------------------------------
    // idling schedule: phases rotate with the number of items sent
    // ---------------------------------------------------------------
    function automatic int traffic_phase();
        return (items_sent / 64) % 4;
    endfunction

    function automatic bit sender_rests();
        case (traffic_phase())
            1:       return $urandom_range(99) < 62;
            3:       return $urandom_range(99) < 15;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (traffic_phase())
            2:       return $urandom_range(99) < 62;
            3:       return $urandom_range(99) < 15;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued items, predicts each one as it is taken
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FUNC_FRAME;
            frame_dlc  <= '0;
            byte0      <= '0;
            byte1      <= '0;
            byte2      <= '0;
            byte3      <= '0;
            byte4      <= '0;
            byte5      <= '0;
            byte6      <= '0;
            byte7      <= '0;
            read_index <= '0;
        end
        else
        begin
            holding = in_valid;
            if (in_valid && in_ready)
            begin
                // item taken: run it through the predictor
                reassemble_step(on_bus, next_reply);
                pending_replies.push_back(next_reply);
                items_sent++;
                if (on_bus.func == FUNC_READ)
                    reads_sent++;
                else
                    frames_sent++;
                holding = 1'b0;
            end
            // valid stays put with its payload until the handshake completes
            if (!holding)
            begin
                if (frame_q.size() != 0 && !sender_rests())
                begin
                    on_bus     <= frame_q[0];
                    func       <= frame_q[0].func;
                    frame_dlc  <= frame_q[0].dlc;
                    byte0      <= frame_q[0].data[0];
                    byte1      <= frame_q[0].data[1];
                    byte2      <= frame_q[0].data[2];
                    byte3      <= frame_q[0].data[3];
                    byte4      <= frame_q[0].data[4];
                    byte5      <= frame_q[0].data[5];
                    byte6      <= frame_q[0].data[6];
                    byte7      <= frame_q[0].data[7];
                    read_index <= frame_q[0].read_index;
                    in_valid   <= 1'b1;
                    void'(frame_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: compares each result against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    err_count++;
                end
                else
                begin
                    got_reply = pending_replies.pop_front();
                    check_field("complete", got_reply.complete, complete);
                    check_field("busy_res", got_reply.busy, busy_res);
                    check_field("msg_len", got_reply.len, msg_len);
                    check_field("read_byte", got_reply.rbyte, read_byte);
                    if (complete === 1'b1)
                        messages_done++;
                    if (msg_len > longest_len)
                        longest_len = msg_len;
                end
            end
            out_ready <= !receiver_stalls();
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        frame_item_t f;
        int r;
        int len;

        rx_count = 0;
        rx_total = 0;
        rx_seq = 4'd0;
        rx_active = 1'b0;
        for (int i = 0; i < MSG_MAX; i++)
            rx_buf[i] = '0;

        // directed part
        frame_q.push_back(read_item(0));                // read with nothing received
        frame_q.push_back(single_frame(1, 0));          // empty message
        f = single_frame(8, 7);
        f.data[7:1] = '1;                               // all-ones payload
        frame_q.push_back(f);
        frame_q.push_back(read_item(6));
        frame_q.push_back(read_item(127));              // beyond msg_len
        frame_q.push_back(single_frame(3, 5));          // length too long for dlc
        frame_q.push_back(single_frame(0, 2));          // dlc zero
        frame_q.push_back(make_frame(8, 8'h3A));        // unknown pci type
        frame_q.push_back(make_frame(8, 8'hF0));
        f = single_frame(15, 7);                        // dlc code above eight
        f.data[7:1] = '0;
        frame_q.push_back(f);
        frame_q.push_back(cons_frame(8, 1));            // consecutive frame while idle
        frame_q.push_back(first_frame(8, 4095));        // oversize first frames
        frame_q.push_back(first_frame(8, MSG_MAX + 1));
        frame_q.push_back(first_frame(1, 5));           // short first frame, no payload
        frame_q.push_back(cons_frame(6, 1));
        frame_q.push_back(first_frame(8, 3));           // length below its own chunk
        frame_q.push_back(cons_frame(1, 1));
        frame_q.push_back(read_item(5));
        frame_q.push_back(first_frame(4, 20));
        frame_q.push_back(cons_frame(8, 2));            // sequence slip
        frame_q.push_back(first_frame(8, 20));
        frame_q.push_back(first_frame(8, 8));           // restart mid-transfer
        frame_q.push_back(cons_frame(3, 1));
        frame_q.push_back(read_item(7));
        frame_q.push_back(read_item(8));

        // long transfers first: sequence wrap, then a buffer overrun
        add_message(111, 1'b0, 1'b0);
        add_reads(111);
        add_message(MSG_MAX, 1'b0, 1'b1);
        add_message(MSG_MAX, 1'b0, 1'b0);
        add_reads(MSG_MAX);

        // random traffic, mostly well-formed messages with random content
        while (frame_q.size() < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                frame_q.push_back(first_frame(full_dlc(), $urandom_range(4095, MSG_MAX + 1)));
                frame_q.push_back(cons_frame(8, 1));
            end
            else if (r < 8)
                frame_q.push_back(noise_frame());
            else if (r < 10)
                frame_q.push_back(cons_frame($urandom_range(15, 0), $urandom_range(15, 0)));
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(40, 0);
                else if (r < 95)
                    len = $urandom_range(MSG_MAX - 1, 41);
                else
                    len = MSG_MAX;
                add_message(len, $urandom_range(5) == 0, $urandom_range(19) == 0);
                add_reads(len);
            end
        end
        total_items = frame_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent < total_items || pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames and %0d buffer reads", frames_sent, reads_sent);
        $display("%0d messages completed, longest msg_len %0d", messages_done, longest_len);
        if (err_count == 0 && pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
